FILE: src/vn1d_pkg.sv
// Package for the 1D octave value-noise engine: widths, hash constants, register codes
// and the cosine blend weight table built at elaboration. No dependencies.
package vn1d_pkg;

    localparam int MAX_OCTAVES        = 8;
    localparam int WEIGHT_TABLE_DEPTH = 256;
    localparam int WT_IDX_W           = $clog2(WEIGHT_TABLE_DEPTH);
    localparam int AMP_IDX_W          = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

    // hash constants
    localparam logic [31:0] HASH_MUL  = 32'd15731;
    localparam logic [31:0] HASH_ADD1 = 32'd789221;
    localparam logic [31:0] HASH_ADD2 = 32'd1376312589;
    localparam logic [30:0] HASH_MASK = 31'h7FFF_FFFF;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    localparam logic [15:0] AMP_ONE  = 16'd32768;
    localparam logic [15:0] AMP_HALF = 16'd16384;
    localparam logic [16:0] W_ONE    = 17'd32768;

    // data widths through the datapath
    localparam int S_W = 34;   // smoothed lattice value
    localparam int P_W = 52;   // blend products and blend sum
    localparam int T_W = 64;   // amplitude-scaled term
    localparam int Q_W = 26;   // rounded Q2.24 term
    localparam int SUM_W = 36;

    // register map, index = paddr[2]
    localparam logic REG_PERSISTENCE = 1'b0;
    localparam logic REG_OCTAVES     = 1'b1;

    typedef logic [16:0] t_wtab [WEIGHT_TABLE_DEPTH];

    // (1 - cos(pi*j/D))/2 in Q1.15, cosine as truncated Q30 Taylor sum
    // Taylor divisors (2k-1)*(2k) for k = 1..8: 2, 12, 30, 56, 90, 132, 182, 240
    function automatic t_wtab build_wtab();
        t_wtab              tab;
        longint unsigned    jr;
        longint unsigned    theta;
        longint unsigned    x2;
        longint unsigned    term;
        longint             c;
        longint             w;
        bit                 far;
        for (int j = 0; j < WEIGHT_TABLE_DEPTH; j++) begin
            far = (2 * j > WEIGHT_TABLE_DEPTH);
            jr  = far ? longint'(WEIGHT_TABLE_DEPTH - j) : longint'(j);
            theta = (64'd3373259426 * jr) / WEIGHT_TABLE_DEPTH;
            x2    = (theta * theta) >> 30;
            term  = 64'd1073741824;
            c     = 64'sd1073741824;
            term = ((term * x2) >> 30) / 64'd2;
            c    = c - longint'(term);
            term = ((term * x2) >> 30) / 64'd12;
            c    = c + longint'(term);
            term = ((term * x2) >> 30) / 64'd30;
            c    = c - longint'(term);
            term = ((term * x2) >> 30) / 64'd56;
            c    = c + longint'(term);
            term = ((term * x2) >> 30) / 64'd90;
            c    = c - longint'(term);
            term = ((term * x2) >> 30) / 64'd132;
            c    = c + longint'(term);
            term = ((term * x2) >> 30) / 64'd182;
            c    = c - longint'(term);
            term = ((term * x2) >> 30) / 64'd240;
            c    = c + longint'(term);
            if (far) c = -c;
            w = ((64'sd1073741824 - c) + 64'sd32768) / 64'sd65536;
            if (w < 0)     w = 0;
            if (w > 32768) w = 32768;
            tab[j] = 17'(w);
        end
        return tab;
    endfunction

    localparam t_wtab W_TABLE = build_wtab();

endpackage

FILE: src/vn1d_hash.sv
// Four-stage pipelined lattice hash: point -> 1 - h/2^30 in Q2.30.
// Depends on vn1d_pkg; advances on i_en.
module vn1d_hash (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_point,
    output logic signed [31:0] o_lattice
);
    import vn1d_pkg::*;

    logic [31:0] r_y_a, r_y_b, r_y_c, r_yy, r_t;
    logic signed [31:0] r_n;
    logic [31:0] n_y, n_h;

    assign n_y = {1'b0, i_point[17:0], 13'b0} ^ i_point;
    assign n_h = r_y_c * r_t + HASH_ADD2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y_a <= n_y;
            r_y_b <= r_y_a;
            r_yy  <= r_y_a * r_y_a;
            r_y_c <= r_y_b;
            r_t   <= r_yy * HASH_MUL + HASH_ADD1;
            r_n   <= ONE_Q30 - $signed({1'b0, n_h[30:0] & HASH_MASK});
        end
    end

    assign o_lattice = r_n;

endmodule

FILE: src/value_noise_1d_octaves.sv
// Top level of the 1D fractal value-noise engine: APB registers, amplitude sweep,
// per-octave lanes and the saturating sum. Depends on vn1d_pkg and vn1d_hash.
//
// One position beat in, one noise beat out, a new position every clock cycle while
// no stall holds it. The path from input acceptance to o_out_valid runs through the input
// register, four hash stages, smoothing + weight lookup, two blend stages, amplitude
// multiply, rounding and the sum/saturate output register. Every octave has a lane
// of its own, so the octave count does not change throughput or latency.
// A stalled output freezes the whole pipe. After reset and after every write
// of persistence the octave amplitudes are recomputed one per cycle; the input is
// stalled during that sweep.
module value_noise_1d_octaves (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // position beats
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [31:0]  i_position,
    // noise beats
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic signed [31:0] o_noise_value,
    // APB
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import vn1d_pkg::*;

    localparam int NSTG = 10;  // valid bits r_vld[1..NSTG] before the output register

    // ---------------- config registers ----------------
    logic [15:0] r_persistence;
    logic [3:0]  r_octaves;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persistence <= AMP_HALF;
            r_octaves     <= 4'd4;
        end else if (wr) begin
            case (paddr[2])
                REG_PERSISTENCE: r_persistence <= pwdata[15:0];
                REG_OCTAVES:     r_octaves     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PERSISTENCE: prdata = {16'b0, r_persistence};
            REG_OCTAVES:     prdata = {28'b0, r_octaves};
            default:         prdata = 32'b0;
        endcase
    end

    // ---------------- amplitude sweep ----------------
    // amp[i] = p^i in Q1.15 with p = persistence clamped to 1.0, one multiply per cycle.
    logic [15:0] r_amp [MAX_OCTAVES];
    logic [AMP_IDX_W-1:0] r_amp_idx;
    logic        r_amp_busy;
    logic [15:0] p_eff;
    logic [31:0] amp_prod;

    assign p_eff    = (r_persistence > AMP_ONE) ? AMP_ONE : r_persistence;
    assign amp_prod = r_amp[r_amp_idx - AMP_IDX_W'(1)] * p_eff + 32'(AMP_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_busy <= 1'b1;
            r_amp_idx  <= '0;
        end else if (wr && paddr[2] == REG_PERSISTENCE) begin
            r_amp_busy <= 1'b1;
            r_amp_idx  <= '0;
        end else if (r_amp_busy) begin
            if (32'(r_amp_idx) == MAX_OCTAVES - 1) r_amp_busy <= 1'b0;
            else                                   r_amp_idx  <= r_amp_idx + AMP_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_amp_busy) begin
            if (r_amp_idx == '0) r_amp[r_amp_idx] <= AMP_ONE;
            else                 r_amp[r_amp_idx] <= amp_prod[30:15];
        end
    end

    // ---------------- pipeline control ----------------
    logic adv, in_acc;
    logic [NSTG:1] r_vld;
    logic r_out_valid;

    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = !adv || r_amp_busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[NSTG-1:1], in_acc};
            r_out_valid <= r_vld[NSTG];
        end
    end

    // stage 1: input capture
    logic [31:0] r1_pos;
    always_ff @(posedge i_clk) begin
        if (adv) r1_pos <= i_position;
    end

    // ---------------- octave lanes ----------------
    logic signed [Q_W-1:0] lane_q [MAX_OCTAVES];

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
        logic [63:0] sp;
        logic [31:0] k;
        logic signed [31:0] nv [4];       // k-1, k, k+1, k+2
        logic [WT_IDX_W-1:0] r_j [2:5];
        logic signed [S_W-1:0] r_s0, r_s1;
        logic [16:0] r_w;
        logic signed [P_W-1:0] r_p0, r_p1, r_b;
        logic signed [T_W-1:0] r_term;
        logic signed [Q_W-1:0] r_q;
        logic signed [T_W-1:0] rnd;

        assign sp = {32'b0, r1_pos} << g;
        assign k  = sp[47:16];

        for (genvar h = 0; h < 4; h++) begin : g_pt
            vn1d_hash u_hash (
                .i_clk     (i_clk),
                .i_en      (adv),
                .i_point   (k + 32'(h) - 32'd1),
                .o_lattice (nv[h])
            );
        end

        assign rnd = r_term + (T_W'(1) <<< 37);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_j[2] <= sp[15 -: WT_IDX_W];
                r_j[3] <= r_j[2];
                r_j[4] <= r_j[3];
                r_j[5] <= r_j[4];
                // stage 6: smoothing and weight lookup
                r_s0 <= (S_W'(nv[1]) <<< 1) + S_W'(nv[0]) + S_W'(nv[2]);
                r_s1 <= (S_W'(nv[2]) <<< 1) + S_W'(nv[1]) + S_W'(nv[3]);
                r_w  <= W_TABLE[r_j[5]];
                // stage 7: blend products
                r_p0 <= P_W'(r_s0 * $signed({1'b0, W_ONE - r_w}));
                r_p1 <= P_W'(r_s1 * $signed({1'b0, r_w}));
                // stage 8
                r_b  <= r_p0 + r_p1;
                // stage 9: octave amplitude
                r_term <= T_W'(r_b * $signed({1'b0, r_amp[g]}));
                // stage 10: round half up to Q2.24
                r_q  <= Q_W'(rnd >>> 38);
            end
        end

        assign lane_q[g] = r_q;
    end

    // ---------------- sum and saturate ----------------
    logic [4:0] n_eff;
    logic signed [SUM_W-1:0] sum;
    logic signed [31:0] r_noise;

    assign n_eff = (32'(r_octaves) > MAX_OCTAVES) ? 5'(MAX_OCTAVES) : {1'b0, r_octaves};

    always_comb begin
        sum = '0;
        for (int i = 0; i < MAX_OCTAVES; i++) begin
            if (i < int'(n_eff)) sum = sum + SUM_W'(lane_q[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (sum > SUM_W'(32'sh7FFF_FFFF))
                r_noise <= 32'sh7FFF_FFFF;
            else if (sum < -SUM_W'(33'sh0_8000_0000))
                r_noise <= 32'sh8000_0000;
            else
                r_noise <= 32'(sum);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_noise;

    // ---------------- assertions ----------------
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_amp_busy |-> !in_acc) else $error("beat accepted during amplitude sweep");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_vld) && $stable(r_noise))
        else $error("pipeline moved while output stalled");

    a_amp0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_amp_busy |-> r_amp[0] == AMP_ONE) else $error("octave 0 amplitude wrong");

endmodule
